// File: sv/modexp_pkg.sv
package modexp_pkg;

   localparam int MOD_WIDTH  = 16;
   localparam int EXP_WIDTH  = 32;
   localparam int PROD_WIDTH = 2 * MOD_WIDTH;

   typedef struct packed {
      logic [MOD_WIDTH-1:0] base;
      logic [EXP_WIDTH-1:0] exponent;
      logic [MOD_WIDTH-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [MOD_WIDTH-1:0] power_result;
      logic                 zero_modulus_error;
   } rsp_type;

   // Modular operation that the shared remainder unit works on
   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_MULTIPLY,
      OP_SQUARE
   } op_type;

   typedef struct packed {
      logic   load;
      logic   form;
      logic   start;
      logic   commit;
      logic   emit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic e_zero;
      logic e_lsb;
      logic e_last;
      logic m_small;
      logic rem_done;
      logic rem_busy;
   } sts_type;

endpackage

// File: sv/modexp_rem.sv
module modexp_rem (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [modexp_pkg::PROD_WIDTH-1:0]      dividend,
   input  logic [modexp_pkg::MOD_WIDTH-1:0]       divisor,
   output logic                                   busy,
   output logic                                   done,
   output logic [modexp_pkg::MOD_WIDTH-1:0]       remainder
);

   localparam int MW    = modexp_pkg::MOD_WIDTH;
   localparam int PW    = modexp_pkg::PROD_WIDTH;
   localparam int CNT_W = $clog2(PW + 1);

   logic [PW-1:0]    div_ff, div_in;
   logic [MW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MW:0]      trial;

   // One quotient bit per cycle, restoring form
   assign trial = {rem_ff, div_ff[PW-1]};

   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         div_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(PW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         div_in = div_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = MW'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[MW-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without a running division");

endmodule

// File: sv/modexp_ctrl.sv
module modexp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  modexp_pkg::sts_type  sts,
   output modexp_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_FORM,
      S_START,
      S_WAIT,
      S_CHECK,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   modexp_pkg::op_type op_ff, op_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.op       = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (sts.m_small) begin
               state_in = S_EMIT;
            end else begin
               op_in    = modexp_pkg::OP_REDUCE;
               state_in = S_FORM;
            end
         end
         S_FORM: begin
            cmd.form = 1'b1;
            state_in = S_START;
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (sts.rem_done) begin
               cmd.commit = 1'b1;
               unique case (op_ff)
                  modexp_pkg::OP_MULTIPLY: begin
                     if (sts.e_last) begin
                        state_in = S_EMIT;
                     end else begin
                        op_in    = modexp_pkg::OP_SQUARE;
                        state_in = S_FORM;
                     end
                  end
                  default: state_in = S_CHECK;
               endcase
            end
         end
         S_CHECK: begin
            if (sts.e_zero) begin
               state_in = S_EMIT;
            end else if (sts.e_lsb) begin
               op_in    = modexp_pkg::OP_MULTIPLY;
               state_in = S_FORM;
            end else begin
               op_in    = modexp_pkg::OP_SQUARE;
               state_in = S_FORM;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= modexp_pkg::OP_REDUCE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      sts.rem_done |-> state_ff == S_WAIT)
      else $error("remainder result arrived outside the wait state");

   a_idle_unit_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !sts.rem_busy)
      else $error("remainder unit busy while controller idle");

endmodule

// File: sv/modexp_dp.sv
module modexp_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  modexp_pkg::req_type  req_data,
   input  modexp_pkg::cmd_type  cmd,
   output modexp_pkg::sts_type  sts,
   output modexp_pkg::rsp_type  rsp_data
);

   localparam int MW = modexp_pkg::MOD_WIDTH;
   localparam int EW = modexp_pkg::EXP_WIDTH;
   localparam int PW = modexp_pkg::PROD_WIDTH;

   logic [MW-1:0]       b_ff, acc_ff, m_ff;
   logic [EW-1:0]       e_ff;
   logic [PW-1:0]       prod_ff, prod_in;
   modexp_pkg::rsp_type rsp_ff;
   logic                rem_busy, rem_done;
   logic [MW-1:0]       rem_value;
   logic                m_small;

   assign m_small = (m_ff[MW-1:1] == '0);

   always_comb begin
      case (cmd.op)
         modexp_pkg::OP_MULTIPLY: prod_in = PW'(acc_ff) * PW'(b_ff);
         modexp_pkg::OP_SQUARE:   prod_in = PW'(b_ff) * PW'(b_ff);
         default:                 prod_in = PW'(b_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         b_ff   <= req_data.base;
         e_ff   <= req_data.exponent;
         m_ff   <= req_data.modulus;
         acc_ff <= MW'(1);
      end
      if (cmd.form) begin
         prod_ff <= prod_in;
      end
      if (cmd.commit) begin
         case (cmd.op)
            modexp_pkg::OP_MULTIPLY: acc_ff <= rem_value;
            modexp_pkg::OP_SQUARE: begin
               b_ff <= rem_value;
               e_ff <= e_ff >> 1;
            end
            default: b_ff <= rem_value;
         endcase
      end
      if (cmd.emit) begin
         rsp_ff.power_result       <= m_small ? '0 : acc_ff;
         rsp_ff.zero_modulus_error <= (m_ff == '0);
      end
   end

   modexp_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .dividend  (prod_ff),
      .divisor   (m_ff),
      .busy      (rem_busy),
      .done      (rem_done),
      .remainder (rem_value)
   );

   always_comb begin
      sts.e_zero   = (e_ff == '0);
      sts.e_lsb    = e_ff[0];
      sts.e_last   = ((e_ff >> 1) == '0);
      sts.m_small  = m_small;
      sts.rem_done = rem_done;
      sts.rem_busy = rem_busy;
   end

   assign rsp_data = rsp_ff;

endmodule

// File: sv/modular_exponentiation.sv
// Modular exponentiation: each request carries a 16-bit base, a 32-bit exponent and a
// 16-bit modulus, and the block returns base^exponent mod modulus on the response
// channel, one response per request, in order. A zero modulus sets zero_modulus_error
// and returns 0; a modulus of one returns 0; an exponent of zero returns 1 otherwise.
// The block works on one request at a time: the request is taken only while the
// controller is idle, but a finished response waits in an output register, so a new
// request may be accepted while the previous response is still stalled. All modular
// work goes through one bit-serial remainder unit that retires one bit of the 32-bit
// product per cycle; each modular operation forms the product, divides it and writes
// the remainder back. A request runs one base reduction, then one square per exponent
// bit below the top set bit plus one multiply per set bit. A zero exponent runs the
// base reduction alone, and a zero or unit modulus skips the modular work entirely.
module modular_exponentiation (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  modexp_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output modexp_pkg::rsp_type  rsp_data
);

   modexp_pkg::cmd_type cmd;
   modexp_pkg::sts_type sts;

   // Sequence the reduce / multiply / square steps
   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold operands, form products and reduce them
   modexp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // A flagged response always carries a zero result
   a_error_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_modulus_error |-> rsp_data.power_result == '0)
      else $error("zero modulus response with nonzero result");

   // No new request while the controller is still working on one
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      sts.rem_busy |-> req_stall)
      else $error("request channel open during a division");

endmodule

// File: sim/tb_modular_exponentiation.sv
module tb_modular_exponentiation;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_REQUESTS  = 290;
   localparam int unsigned QUIET_TAIL       = 40;    // last requests run with no idling
   localparam int unsigned LONG_HOLD_CYCLES = 3000;  // longer than any single request
   localparam int unsigned DRAIN_CYCLES     = 200;
   localparam int unsigned REPORT_LIMIT     = 10;

   // One outstanding request and the response it must produce
   typedef struct {
      modexp_pkg::req_type request;
      modexp_pkg::rsp_type answer;
   } pending_type;

   // Scoreboard: predict base^exponent mod modulus for every accepted request and
   // compare the responses against those predictions in order.
   class modexp_scoreboard;
      pending_type outstanding_q[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Right-to-left square and multiply, every product at 64-bit width
      static function modexp_pkg::rsp_type predict_power(modexp_pkg::req_type r);
         modexp_pkg::rsp_type              answer;
         logic [63:0]                      modulus;
         logic [63:0]                      base_pow;
         logic [63:0]                      acc;
         logic [modexp_pkg::EXP_WIDTH-1:0] exp_bits;
         modulus  = 64'(r.modulus);
         answer.power_result       = '0;
         answer.zero_modulus_error = 1'b0;
         if (modulus == 0) begin
            answer.zero_modulus_error = 1'b1;
            return answer;
         end
         // A unit modulus starts at zero and stays there, even for a zero exponent
         acc      = (modulus == 1) ? 64'd0 : 64'd1;
         base_pow = 64'(r.base) % modulus;
         exp_bits = r.exponent;
         while (exp_bits != 0) begin
            if (exp_bits[0]) acc = (acc * base_pow) % modulus;
            exp_bits = exp_bits >> 1;
            base_pow = (base_pow * base_pow) % modulus;
         end
         answer.power_result = acc[modexp_pkg::MOD_WIDTH-1:0];
         return answer;
      endfunction

      function void note_request(modexp_pkg::req_type r);
         pending_type p;
         p.request = r;
         p.answer  = predict_power(r);
         outstanding_q.push_back(p);
      endfunction

      function void check_response(modexp_pkg::rsp_type got);
         pending_type p;
         if (outstanding_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("modexp check: response power_result=%0h zero_modulus_error=%0b %s",
                        got.power_result, got.zero_modulus_error, "with no request outstanding");
            return;
         end
         p = outstanding_q.pop_front();
         if (got.power_result !== p.answer.power_result ||
             got.zero_modulus_error !== p.answer.zero_modulus_error) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("modexp check: base=%0h exponent=%0h modulus=%0h: %s %0h/%0b, got %0h/%0b",
                        p.request.base, p.request.exponent, p.request.modulus,
                        "expected result/error", p.answer.power_result,
                        p.answer.zero_modulus_error, got.power_result, got.zero_modulus_error);
         end
      endfunction

      function int unsigned pending();
         return outstanding_q.size();
      endfunction
   endclass

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   modexp_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   modexp_pkg::rsp_type rsp_data;

   // Flags shared between the request and response sides
   logic quiet   = 1'b0;   // suppress all idling on both sides
   logic hold_go = 1'b0;   // ask the response side for its long hold-off

   modexp_scoreboard scoreboard = new();

   modular_exponentiation u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5ns clock = ~clock;

   // Watch both channels at the edge: a request is taken, or a response is
   // retired, when valid is high and stall is low.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) scoreboard.note_request(req_data);
         if (rsp_valid && !rsp_stall) scoreboard.check_response(rsp_data);
      end
   end

   // Offer one request, maybe after an idle burst, and hold it until accepted.
   // Valid is only lowered when a gap is actually inserted, so back-to-back
   // requests keep valid high without a toggle in the same step.
   task automatic send_request(input logic [modexp_pkg::MOD_WIDTH-1:0] b,
                               input logic [modexp_pkg::EXP_WIDTH-1:0] e,
                               input logic [modexp_pkg::MOD_WIDTH-1:0] m);
      modexp_pkg::req_type r;
      r.base     = b;
      r.exponent = e;
      r.modulus  = m;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Response side: random stall bursts, one long hold-off so the block backs
   // up into its input, and no stalls at all once the quiet tail begins.
   initial begin : response_side
      logic hold_done;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      logic [modexp_pkg::MOD_WIDTH-1:0] b;
      logic [modexp_pkg::EXP_WIDTH-1:0] e;
      logic [modexp_pkg::MOD_WIDTH-1:0] m;
      int unsigned                      exp_len;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero modulus, unit modulus, zero exponent, zero base, extremes
      send_request(16'h1234, 32'd5,          16'h0000);
      send_request(16'hFFFF, 32'hFFFF_FFFF,  16'h0000);
      send_request(16'h0007, 32'd0,          16'h0001);
      send_request(16'hFFFF, 32'hFFFF_FFFF,  16'h0001);
      send_request(16'h1234, 32'd0,          16'hFFFF);
      send_request(16'h0000, 32'd0,          16'h0007);
      send_request(16'h0000, 32'd9,          16'h000D);
      send_request(16'hFFFF, 32'hFFFF_FFFF,  16'hFFFF);
      send_request(16'hFFFE, 32'hFFFF_FFFF,  16'hFFFF);
      send_request(16'hFFFF, 32'hFFFF_FFFF,  16'hFFFD);
      send_request(16'h0003, 32'd1,          16'h0002);
      send_request(16'hFFFF, 32'd2,          16'hFFFB);
      send_request(16'h0002, 32'h8000_0000,  16'hFFF1);
      send_request(16'd12345, 32'd65537,     16'd65521);
      send_request(16'd40000, 32'd3,         16'd17);
      send_request(16'hAAAA, 32'h5555_5555,  16'hFFFF);
      send_request(16'h5555, 32'hAAAA_AAAA,  16'h8000);
      send_request(16'h0001, 32'hFFFF_FFFF,  16'h0002);

      // Random: start with the long response hold-off while requests keep coming
      hold_go = 1'b1;
      for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;

         case ($urandom_range(0, 19))
            0:       m = 16'h0000;
            1:       m = 16'h0001;
            2:       m = 16'hFFFF;
            3, 4:    m = 16'($urandom_range(2, 20));
            default: m = 16'($urandom_range(2, 65535));
         endcase

         case ($urandom_range(0, 9))
            0:       b = 16'h0000;
            1:       b = 16'hFFFF;
            2:       b = m;
            default: b = 16'($urandom);
         endcase

         // Keep most exponents short; full-width ones are the slow case
         if ($urandom_range(0, 4) == 0) begin
            e = $urandom;
         end else begin
            exp_len = $urandom_range(1, 10);
            e = $urandom & ((32'h1 << exp_len) - 1);
         end

         send_request(b, e, m);
      end
      req_valid <= 1'b0;

      // Let the last acceptance be recorded, drain, then watch for strays
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hard stop: several times the slowest legal run
   initial begin : watchdog
      #50_000_000ns;
      $display("tb: failure");
      $finish;
   end

endmodule
